[hdl/tvfg_pkg.sv]
`default_nettype none
package tvfg_pkg;

	localparam int CfgDataW = 10;
	localparam int CfgIdxW  = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TEMP_LOW     = 3'd0,
		REG_TEMP_HIGH    = 3'd1,
		REG_FREQ_FLOOR   = 3'd2,
		REG_FREQ_CEILING = 3'd3,
		REG_VOLT_LOW     = 3'd4,
		REG_VOLT_HIGH    = 3'd5,
		REG_RISE_TICKS   = 3'd6,
		REG_FALL_TICKS   = 3'd7
	} cfg_reg_e;

	typedef struct packed {
		logic signed [7:0] temp_low;
		logic signed [7:0] temp_high;
		logic [8:0]        freq_floor;
		logic [8:0]        freq_ceiling;
		logic [9:0]        volt_low;
		logic [9:0]        volt_high;
		logic [3:0]        rise_ticks;
		logic [3:0]        fall_ticks;
	} cfg_t;

	typedef struct packed {
		logic [8:0] freq;
		logic       hot;
		logic       mode;
		logic [3:0] trend;
		logic [1:0] vtick;
		logic [7:0] prev_temp;
	} gov_state_t;

	typedef struct packed {
		logic              power_on;
		logic signed [7:0] temperature;
		logic [9:0]        volt_sample;
	} tick_t;

	localparam logic signed [7:0] TEMP_LOW_RST     = 8'sd60;
	localparam logic signed [7:0] TEMP_HIGH_RST    = 8'sd65;
	localparam logic [8:0]        FREQ_FLOOR_RST   = 9'd100;
	localparam logic [8:0]        FREQ_CEILING_RST = 9'd360;
	localparam logic [9:0]        VOLT_LOW_RST     = 10'd450;
	localparam logic [9:0]        VOLT_HIGH_RST    = 10'd460;
	localparam logic [3:0]        RISE_TICKS_RST   = 4'd1;
	localparam logic [3:0]        FALL_TICKS_RST   = 4'd2;

	localparam logic [9:0] STEP_DOWN_TEMP = 10'd40;
	localparam logic [9:0] STEP_DOWN_VOLT = 10'd20;
	localparam logic [9:0] STEP_UP        = 10'd20;
	localparam logic [1:0] VOLT_CHECK_TICKS = 2'd2;

	function automatic logic [8:0] lower_freq(input logic [8:0] freq, input logic [8:0] floor_v,
			input logic [9:0] step);
		logic [9:0] lim;
		logic [9:0] diff;
		begin
			lim  = {1'b0, floor_v} + step;
			diff = {1'b0, freq} - step;
			if ({1'b0, freq} < lim) begin
				lower_freq = floor_v;
			end else begin
				lower_freq = diff[8:0];
			end
		end
	endfunction

endpackage
`default_nettype wire

[hdl/tvfg_cfg.sv]
`default_nettype none
module tvfg_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [tvfg_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [tvfg_pkg::CfgDataW-1:0]   cfg_data,
	output tvfg_pkg::cfg_t                       cfg
);
	import tvfg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_low     <= TEMP_LOW_RST;
			cfg_q.temp_high    <= TEMP_HIGH_RST;
			cfg_q.freq_floor   <= FREQ_FLOOR_RST;
			cfg_q.freq_ceiling <= FREQ_CEILING_RST;
			cfg_q.volt_low     <= VOLT_LOW_RST;
			cfg_q.volt_high    <= VOLT_HIGH_RST;
			cfg_q.rise_ticks   <= RISE_TICKS_RST;
			cfg_q.fall_ticks   <= FALL_TICKS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_TEMP_LOW:     cfg_q.temp_low     <= cfg_data[7:0];
				REG_TEMP_HIGH:    cfg_q.temp_high    <= cfg_data[7:0];
				REG_FREQ_FLOOR:   cfg_q.freq_floor   <= cfg_data[8:0];
				REG_FREQ_CEILING: cfg_q.freq_ceiling <= cfg_data[8:0];
				REG_VOLT_LOW:     cfg_q.volt_low     <= cfg_data[9:0];
				REG_VOLT_HIGH:    cfg_q.volt_high    <= cfg_data[9:0];
				REG_RISE_TICKS:   cfg_q.rise_ticks   <= cfg_data[3:0];
				REG_FALL_TICKS:   cfg_q.fall_ticks   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[hdl/tvfg_state.sv]
`default_nettype none
module tvfg_state (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        upd,
	input  wire tvfg_pkg::tick_t  tick,
	input  wire tvfg_pkg::cfg_t   cfg,
	output tvfg_pkg::gov_state_t nxt
);
	import tvfg_pkg::*;

	gov_state_t st_q;
	gov_state_t n;
	logic       act;
	logic [3:0] limit;
	logic [9:0] raised;

	always_comb begin
		n      = st_q;
		act    = 1'b0;
		limit  = cfg.fall_ticks;
		raised = {1'b0, st_q.freq};
		if (!tick.power_on) begin
			if (st_q.hot && (tick.temperature < cfg.temp_low)) begin
				n.hot = 1'b0;
			end
		end else if (!st_q.mode) begin
			if (tick.volt_sample < cfg.volt_low) begin
				n.trend = '0;
				n.mode  = 1'b1;
			end else if (st_q.prev_temp == 8'd0) begin
				n.prev_temp = tick.temperature;
			end else begin
				if ($signed(st_q.prev_temp) < tick.temperature) begin
					limit = cfg.rise_ticks;
				end
				if (st_q.trend >= limit) begin
					n.trend = '0;
					act     = 1'b1;
				end else begin
					n.trend = st_q.trend + 4'd1;
				end
				n.prev_temp = tick.temperature;
				if (act) begin
					if (tick.temperature >= cfg.temp_high) begin
						if (st_q.freq > cfg.freq_floor) begin
							n.freq = lower_freq(st_q.freq, cfg.freq_floor, STEP_DOWN_TEMP);
						end else begin
							n.freq = cfg.freq_floor;
							n.hot  = 1'b1;
						end
					end else if (tick.temperature < cfg.temp_low) begin
						n.hot = 1'b0;
						if (st_q.freq <= cfg.freq_ceiling) begin
							raised = {1'b0, st_q.freq} + STEP_UP;
						end
						if (raised > {1'b0, cfg.freq_ceiling}) begin
							n.freq = cfg.freq_ceiling;
						end else begin
							n.freq = raised[8:0];
						end
					end else begin
						n.hot = 1'b0;
					end
				end
			end
		end else begin
			if (st_q.vtick == VOLT_CHECK_TICKS) begin
				if (tick.volt_sample >= cfg.volt_low) begin
					n.vtick = 2'd0;
					if (tick.volt_sample > cfg.volt_high) begin
						n.mode = 1'b0;
					end
				end else begin
					n.freq  = lower_freq(st_q.freq, cfg.freq_floor, STEP_DOWN_VOLT);
					n.vtick = 2'd1;
				end
			end else begin
				n.vtick = st_q.vtick + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.freq      <= FREQ_CEILING_RST;
			st_q.hot       <= 1'b0;
			st_q.mode      <= 1'b0;
			st_q.trend     <= '0;
			st_q.vtick     <= '0;
			st_q.prev_temp <= '0;
		end else if (upd) begin
			st_q <= n;
		end
	end

	assign nxt = n;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(st_q)) else $error("governor state changed without an item");
	a_hot_pwr: assert property (@(posedge clk) disable iff (!arst_n)
		upd && !tick.power_on |-> (n.freq == st_q.freq) && (n.mode == st_q.mode))
		else $error("power-off item changed frequency or mode");
	a_mode_trend: assert property (@(posedge clk) disable iff (!arst_n)
		upd && !st_q.mode && n.mode |-> n.trend == 4'd0)
		else $error("trend count kept on entering voltage mode");

endmodule
`default_nettype wire

[hdl/thermal_voltage_freq_governor_core.sv]
`default_nettype none
// Each item is one monitoring tick and gives exactly one result item holding the
// target frequency, the too-hot flag and the regulation mode after that tick. The
// tick is captured in an input register, and the whole governor update is done
// combinationally from that register into the result register, so a tick is
// accepted every cycle unless both registers hold items and the output is stalled.
// Configuration registers are written through the plain write port and
// should only be changed while no tick is in flight.
module thermal_voltage_freq_governor_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [tvfg_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [tvfg_pkg::CfgDataW-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          power_on,
	input  wire logic signed [7:0]             temperature,
	input  wire logic [9:0]                    volt_sample,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [8:0]                         freq_target,
	output logic                               too_hot,
	output logic                               volt_mode
);
	import tvfg_pkg::*;

	cfg_t       cfg;
	gov_state_t nxt;
	tick_t      tick_s1;
	logic       vld_s1;
	logic       out_vld_q;
	logic       out_load;
	logic       adv;
	logic [8:0] freq_q;
	logic       hot_q;
	logic       mode_q;

	assign out_load = !out_vld_q || !out_stall;
	assign adv      = vld_s1 && out_load;
	assign in_stall = vld_s1 && !out_load;

	tvfg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tvfg_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.tick   (tick_s1),
		.cfg    (cfg),
		.nxt    (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			tick_s1.power_on    <= power_on;
			tick_s1.temperature <= temperature;
			tick_s1.volt_sample <= volt_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			freq_q <= nxt.freq;
			hot_q  <= nxt.hot;
			mode_q <= nxt.mode;
		end
	end

	assign out_valid   = out_vld_q;
	assign freq_target = freq_q;
	assign too_hot     = hot_q;
	assign volt_mode   = mode_q;

	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid) else $error("processed item produced no result");
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1 && out_valid && out_stall)
		else $error("input stalled with nothing pending");
	a_res_val: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (freq_target == $past(nxt.freq)) && (volt_mode == $past(nxt.mode)))
		else $error("result register does not match updated state");

endmodule
`default_nettype wire
